// File: hdl/assert_macros.svh
// assertion macros shared by the receiver rtl
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: hdl/ftrr_pkg.sv
// types and constants of the force/torque record receiver
// no dependencies
package ftrr_pkg;

  localparam int RECORD_BYTES   = 36;
  localparam int POSITION_LIMIT = 37;
  localparam int POS_W          = 6;
  localparam int WORD_W         = 32;
  localparam int VALUE_W        = 48;
  localparam int LANES          = 6;
  localparam int FORCE_LANES    = 3;
  localparam int RECORD_WORDS   = 9;
  localparam int WORD_IDX_W     = 4;

  // config register indexes
  localparam logic CFG_FORCE_SCALE  = 1'b0;
  localparam logic CFG_TORQUE_SCALE = 1'b1;

  typedef enum logic [1:0] {
    OUTCOME_GOOD   = 2'd0,
    OUTCOME_LENGTH = 2'd1,
    OUTCOME_STALE  = 2'd2
  } outcome_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [WORD_W-1:0]  seq;
    logic [WORD_W-1:0]  status;
    logic [WORD_W-1:0]  good;
    logic [WORD_W-1:0]  lost;
    logic [WORD_W-1:0]  stale;
  } meta_t;

endpackage

// File: hdl/ftrr_scale_lane.sv
// one scaling lane: magnitude times q0.32 scale, round half away, saturate to 48 bits
// depends on ftrr_pkg
module ftrr_scale_lane #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              neg_i,
  input  logic [ftrr_pkg::WORD_W-1:0]       mag_i,
  input  logic [ftrr_pkg::WORD_W-1:0]       scale_i,
  output logic [ftrr_pkg::VALUE_W-1:0]      value_o
);
  import ftrr_pkg::*;

  localparam int PROD_W = 2 * WORD_W;
  localparam int SH     = WORD_W - FRACTION_BITS;
  localparam logic [PROD_W:0] RND = (SH > 0) ? ((PROD_W+1)'(1) << ((SH > 0) ? SH - 1 : 0))
                                             : '0;
  localparam logic [PROD_W:0] POS_LIM = (PROD_W+1)'((64'd1 << (VALUE_W-1)) - 64'd1);
  localparam logic [PROD_W:0] NEG_LIM = (PROD_W+1)'(64'd1 << (VALUE_W-1));

  logic [PROD_W-1:0]  prod_r;
  logic               neg_r;
  logic [PROD_W:0]    rounded;
  logic [PROD_W:0]    limit;
  logic [VALUE_W-1:0] mag48;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mag_i * scale_i;
      neg_r  <= neg_i;
    end
  end

  always_comb begin
    rounded = ({1'b0, prod_r} + RND) >> SH;
    limit   = neg_r ? NEG_LIM : POS_LIM;
    mag48   = (rounded > limit) ? limit[VALUE_W-1:0] : rounded[VALUE_W-1:0];
    value_o = neg_r ? (VALUE_W'(0) - mag48) : mag48;
  end

endmodule

// File: hdl/force_torque_record_receiver.sv
// top level of the force/torque record receiver: byte capture, sequence check,
// counters and six scaling lanes; depends on ftrr_pkg, ftrr_scale_lane, assert_macros.svh
//
//  channel  dir  handshake          payload
//  in_      in   tvalid/tready      tdata[7:0] data_byte, tlast end_of_datagram
//  out_     out  tvalid/tready      tuser[1:0] outcome, tdata[447:0] values and totals
//  cfg_     in   valid/ready        index 0 force_scale, 1 torque_scale; data 32 bits
//
// one byte is taken every cycle while in_tready is high; the result of a datagram passes
// through the job register, the lane product register and the output register
// rst_n is synchronous; it clears position, sequence, status, counters and valids,
// and loads both scales with 4295
// a stalled output holds the pipeline; bytes keep flowing while the job slot is free
`include "assert_macros.svh"
module force_torque_record_receiver #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic         in_tlast,    // end_of_datagram
  output logic         out_tvalid,
  input  logic         out_tready,
  // [47:0] force_x, [95:48] force_y, [143:96] force_z, [191:144] torque_x,
  // [239:192] torque_y, [287:240] torque_z, [319:288] record_sequence,
  // [351:320] latched_status, [383:352] good_total, [415:384] lost_total,
  // [447:416] stale_total
  output logic [447:0] out_tdata,
  output logic [1:0]   out_tuser,   // [1:0] outcome
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import ftrr_pkg::*;

  // configuration
  logic [WORD_W-1:0] force_scale_r, torque_scale_r;

  // capture and sequence state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [WORD_W-1:0] rec_w_r [RECORD_WORDS];
  logic [WORD_W-1:0] prev_r, prev_nxt;
  logic [WORD_W-1:0] hold_r, hold_nxt;
  logic [WORD_W-1:0] good_r, good_nxt;
  logic [WORD_W-1:0] lost_r, lost_nxt;
  logic [WORD_W-1:0] stale_r, stale_nxt;

  // pipeline
  logic              s1_v_r, s2_v_r, out_v_r;
  meta_t             s1_meta_r, s2_meta_r, out_meta_r, job_meta;
  logic              s1_neg_r [LANES];
  logic [WORD_W-1:0] s1_mag_r [LANES];
  logic [VALUE_W-1:0] lane_val [LANES];
  logic [VALUE_W-1:0] out_val_r [LANES];
  logic              out_en, s2_en, s1_en;

  logic              in_acc, job;
  logic [WORD_W-1:0] count_c [LANES];
  logic              neg_c [LANES];
  logic [WORD_W-1:0] mag_c [LANES];
  logic [WORD_W-1:0] seq_w, status_w, diff;
  logic              len_ok, stale;
  logic [1:0]        byte_lane;

  assign out_en    = !out_v_r || out_tready;
  assign s2_en     = !s2_v_r || out_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign in_tready = s1_en;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign job       = in_acc && in_tlast;

  assign byte_lane = ~pos_r[1:0];

  always_comb begin
    seq_w     = rec_w_r[0];
    status_w  = rec_w_r[2];
    diff      = seq_w - prev_r;
    len_ok    = (pos_r == POS_W'(RECORD_BYTES - 1));
    stale     = (diff == '0) || diff[WORD_W-1];
    for (int i = 0; i < LANES; i++) begin
      count_c[i] = (i == LANES - 1) ? {rec_w_r[RECORD_WORDS-1][WORD_W-1:8], in_tdata}
                                    : rec_w_r[3 + i];
      neg_c[i]   = count_c[i][WORD_W-1];
      mag_c[i]   = neg_c[i] ? (WORD_W'(0) - count_c[i]) : count_c[i];
    end

    if (in_tlast) begin
      pos_nxt = '0;
    end else if (pos_r < POS_W'(POSITION_LIMIT)) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end

    prev_nxt  = prev_r;
    hold_nxt  = hold_r;
    good_nxt  = good_r;
    lost_nxt  = lost_r;
    stale_nxt = stale_r;
    if (in_tlast && len_ok) begin
      prev_nxt = seq_w;
      if (status_w != '0) hold_nxt = status_w;
      if (stale) begin
        stale_nxt = stale_r + WORD_W'(1);
      end else begin
        good_nxt = good_r + WORD_W'(1);
        lost_nxt = lost_r + diff - WORD_W'(1);
      end
    end

    job_meta.outcome = !len_ok ? OUTCOME_LENGTH : (stale ? OUTCOME_STALE : OUTCOME_GOOD);
    job_meta.seq     = len_ok ? seq_w : '0;
    job_meta.status  = hold_nxt;
    job_meta.good    = good_nxt;
    job_meta.lost    = lost_nxt;
    job_meta.stale   = stale_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_scale_r  <= WORD_W'(4295);
      torque_scale_r <= WORD_W'(4295);
      pos_r          <= '0;
      prev_r         <= '0;
      hold_r         <= '0;
      good_r         <= '0;
      lost_r         <= '0;
      stale_r        <= '0;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FORCE_SCALE:  force_scale_r  <= cfg_data;
          CFG_TORQUE_SCALE: torque_scale_r <= cfg_data;
          default:          force_scale_r  <= force_scale_r;
        endcase
      end
      if (in_acc) begin
        pos_r   <= pos_nxt;
        prev_r  <= prev_nxt;
        hold_r  <= hold_nxt;
        good_r  <= good_nxt;
        lost_r  <= lost_nxt;
        stale_r <= stale_nxt;
      end
      if (s1_en)  s1_v_r  <= job;
      if (s2_en)  s2_v_r  <= s1_v_r;
      if (out_en) out_v_r <= s2_v_r;
    end
  end

  // record bytes land in their big-endian word slot
  always_ff @(posedge clk) begin
    if (in_acc && (pos_r < POS_W'(RECORD_BYTES))) begin
      rec_w_r[pos_r[WORD_IDX_W+1:2]][{byte_lane, 3'b000} +: 8] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && job) begin
      s1_meta_r <= job_meta;
      for (int i = 0; i < LANES; i++) begin
        s1_neg_r[i] <= neg_c[i];
        s1_mag_r[i] <= mag_c[i];
      end
    end
    if (s2_en) s2_meta_r <= s1_meta_r;
    if (out_en) begin
      out_meta_r <= s2_meta_r;
      for (int i = 0; i < LANES; i++) begin
        out_val_r[i] <= (s2_meta_r.outcome == OUTCOME_GOOD) ? lane_val[i] : '0;
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ftrr_scale_lane #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (s2_en),
      .neg_i   (s1_neg_r[g]),
      .mag_i   (s1_mag_r[g]),
      .scale_i ((g < FORCE_LANES) ? force_scale_r : torque_scale_r),
      .value_o (lane_val[g])
    );
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_meta_r.outcome;
  assign out_tdata  = {out_meta_r.stale, out_meta_r.lost, out_meta_r.good,
                       out_meta_r.status, out_meta_r.seq,
                       out_val_r[5], out_val_r[4], out_val_r[3],
                       out_val_r[2], out_val_r[1], out_val_r[0]};

  `ASSERT_NEVER(a_pos_range, clk, rst_n, pos_r > POS_W'(POSITION_LIMIT))
  `ASSERT_PROP(a_job_loads, clk, rst_n, (in_tvalid && in_tready && in_tlast) |=> s1_v_r)
  `ASSERT_PROP(a_zero_values, clk, rst_n,
    (out_v_r && (out_meta_r.outcome != OUTCOME_GOOD)) |-> (out_tdata[287:0] == '0))
  `ASSERT_PROP(a_good_stable, clk, rst_n,
    !(in_tvalid && in_tready && in_tlast) |=> $stable(good_r) && $stable(stale_r))
  `ASSERT_PROP(a_s1_hold, clk, rst_n, (s1_v_r && !s2_en) |=> ($stable(s1_meta_r) && s1_v_r))

endmodule
